>>> rtl/atvr_pkg.sv
`timescale 1ns / 1ps
package atvr_pkg;
    localparam int AXIS_BITS_DEF = 7;
    localparam int OUT_COORD_BITS_DEF = 9;
    localparam int CFG_W = 60;
    localparam int CFG_IDX_W = 3;
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [2:0] REG_GAINS_Y = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y = 3'd1;
    localparam logic [2:0] REG_GAINS_X = 3'd2;
    localparam logic [2:0] REG_OFFSET_X = 3'd3;
    localparam logic [2:0] REG_GAINS_Z = 3'd4;
    localparam logic [2:0] REG_OFFSET_Z = 3'd5;
    localparam logic [2:0] REG_SIZES = 3'd6;
    typedef struct packed {
        logic [1:0]  cmd;
        logic [20:0] src_addr;
        logic signed [15:0] src_value;
        logic [8:0]  out_row;
        logic [8:0]  out_col;
        logic [8:0]  out_slice;
    } t_in_item;
    typedef struct packed {
        logic signed [23:0] sample_value;
        logic outside;
    } t_out_item;
endpackage

>>> rtl/atvr_stream_if.sv
`timescale 1ns / 1ps
interface atvr_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

>>> rtl/atvr_mac.sv
`timescale 1ns / 1ps
// shared multiply-accumulate: one 36x18 product per cycle, optionally weighted by 2^24,
// into a wide accumulator; a clear loads the init value plus the product when enabled
module atvr_mac (
    input  logic i_clk,
    input  logic i_clr,
    input  logic i_en,
    input  logic i_shift,
    input  logic signed [35:0] i_a,
    input  logic signed [17:0] i_b,
    input  logic signed [65:0] i_init,
    output logic signed [65:0] o_acc
);
    logic signed [65:0] r_acc;
    logic signed [65:0] n_acc;
    logic signed [53:0] prod;
    logic signed [65:0] term;
    assign prod = i_a * i_b;
    assign term = i_en ? (i_shift ? (66'(prod) <<< 24) : 66'(prod)) : '0;
    always_comb begin
        n_acc = r_acc;
        if (i_clr) n_acc = i_init + term;
        else if (i_en) n_acc = r_acc + term;
    end
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end
    assign o_acc = r_acc;
endmodule

>>> rtl/affine_trilinear_volume_resampler.sv
`timescale 1ns / 1ps
// load and restart: accepted while idle, and ready stays high after them
// sample: the result is registered once the output is free, and no new beat is accepted until then;
// 9 mapping products and two products per neighbour share one multiplier
// the volume memory is read once per neighbour at a single port; a waiting result
// holds only a finishing sample; reset (synchronous, active low) restores register
// defaults and the minimum, volume contents are kept and undefined until loaded
module affine_trilinear_volume_resampler #(
    parameter int AXIS_BITS = atvr_pkg::AXIS_BITS_DEF,
    parameter int OUT_COORD_BITS = atvr_pkg::OUT_COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [atvr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [atvr_pkg::CFG_W-1:0] i_cfg_data,
    atvr_stream_if.sink   s_in,
    atvr_stream_if.source m_out
);
    localparam int AW = 3 * AXIS_BITS;
    localparam int DEPTH = 1 << AW;
    localparam int AXIS_MAX = 1 << AXIS_BITS;
    localparam int CB = OUT_COORD_BITS > 9 ? 9 : OUT_COORD_BITS;
    localparam logic [3:0] ST_IDLE = 4'd0, ST_MAP = 4'd1, ST_FLOOR = 4'd2,
        ST_ADDR = 4'd3, ST_READ = 4'd4, ST_WGT = 4'd5, ST_MUL = 4'd6,
        ST_RND = 4'd7, ST_OUT = 4'd8, ST_LO = 4'd9;

    typedef atvr_pkg::t_out_item t_out_q;

    logic [59:0] r_gain [3];
    logic [31:0] r_off [3];
    logic [23:0] r_sizes;
    logic signed [15:0] r_min;
    logic signed [15:0] mem [DEPTH];
    logic [3:0] r_st;
    logic [3:0] r_cnt;
    logic [8:0] r_crd [3];
    logic signed [53:0] r_pos [3];
    logic [15:0] r_fr [3];
    logic signed [15:0] r_fl [3];
    logic [8:0] r_sz [3];
    logic [17:0] r_plane;
    logic [AW-1:0] r_addr;
    logic signed [15:0] r_vox;
    logic [48:0] r_w;
    logic r_ovalid;
    t_out_q r_out;

    // mac control
    logic mac_clr, mac_en, mac_shift;
    logic signed [35:0] mac_a;
    logic signed [17:0] mac_b;
    logic signed [65:0] mac_init, acc;
    atvr_mac u_mac (.i_clk(i_clk), .i_clr(mac_clr), .i_en(mac_en), .i_shift(mac_shift),
        .i_a(mac_a), .i_b(mac_b), .i_init(mac_init), .o_acc(acc));

    logic [1:0] ax, pk;
    logic [2:0] nb;
    assign ax = r_cnt[3:2] == 2'd3 ? 2'd2 : r_cnt[3:2];
    assign nb = r_cnt[2:0];

    logic [8:0] szc [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            szc[k] = {1'b0, r_sizes[8*k +: 8]};
            if (int'(szc[k]) > AXIS_MAX) szc[k] = 9'(AXIS_MAX);
        end
    end

    logic in_ok;
    logic out_free, out_set;
    assign s_in.ready = (r_st == ST_IDLE);
    assign in_ok = s_in.valid && s_in.ready;

    // per-neighbour index and address pieces
    logic [15:0] iy, ix, iz;
    logic [31:0] flat;
    assign iy = 16'(r_fl[0] + 16'(nb[0]));
    assign ix = 16'(r_fl[1] + 16'(nb[1]));
    assign iz = 16'(r_fl[2] + 16'(nb[2]));
    logic [16:0] w0, w1, w2;
    assign w0 = nb[0] ? {1'b0, r_fr[0]} : 17'(17'h10000 - {1'b0, r_fr[0]});
    assign w1 = nb[1] ? {1'b0, r_fr[1]} : 17'(17'h10000 - {1'b0, r_fr[1]});
    assign w2 = nb[2] ? {1'b0, r_fr[2]} : 17'(17'h10000 - {1'b0, r_fr[2]});

    logic outside_c;
    always_comb begin
        outside_c = 1'b0;
        for (int k = 0; k < 3; k++)
            if (r_fl[k] < 0 || r_fl[k] > $signed({7'd0, r_sz[k]}) - 16'sd2) outside_c = 1'b1;
    end

    assign out_free = !r_ovalid || m_out.ready;
    assign out_set = out_free && ((r_st == ST_ADDR && outside_c) || r_st == ST_OUT);

    logic [19:0] gsel;
    always_comb begin
        pk = r_cnt[1:0] == 2'd3 ? 2'd2 : r_cnt[1:0];
        gsel = r_gain[ax][20*pk +: 20];
        mac_clr = 1'b0; mac_en = 1'b0; mac_shift = 1'b0;
        mac_a = '0; mac_b = '0; mac_init = '0;
        if (in_ok && s_in.payload.cmd == atvr_pkg::CMD_SAMPLE) begin
            mac_clr = 1'b1;
        end
        case (r_st)
            ST_MAP: begin
                // offset loads with the first product, last step of an axis only stores
                if (r_cnt[1:0] == 2'd0) begin
                    mac_clr = 1'b1;
                    mac_init = 66'(signed'(r_off[ax]));
                end
                mac_en = (r_cnt[1:0] != 2'd3);
                mac_a = 36'(signed'(gsel));
                mac_b = 18'({9'd0, r_crd[pk]});
            end
            ST_FLOOR: begin
                mac_clr = 1'b1;
            end
            ST_MUL: begin
                // upper weight bits, weighted by 2^24
                mac_en = 1'b1;
                mac_shift = 1'b1;
                mac_a = 36'({11'd0, r_w[48:24]});
                mac_b = 18'(r_vox);
            end
            ST_LO: begin
                mac_en = 1'b1;
                mac_a = 36'({12'd0, r_w[23:0]});
                mac_b = 18'(r_vox);
            end
            default: ;
        endcase
    end
    assign flat = 32'(iy) + 32'(ix) * 32'(r_sz[0]) + 32'(iz) * 32'(r_plane);

    logic [39:0] rnd;
    assign rnd = 40'd1 << 39;
    logic signed [65:0] accr;
    assign accr = acc + 66'(rnd);

    always_ff @(posedge i_clk) begin
        if (in_ok && s_in.payload.cmd == atvr_pkg::CMD_LOAD)
            mem[AW'(s_in.payload.src_addr)] <= s_in.payload.src_value;
        if (r_st == ST_READ) r_vox <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain[0] <= 60'd65536;
            r_gain[1] <= 60'd65536 << 20;
            r_gain[2] <= 60'd65536 << 40;
            r_off[0] <= '0; r_off[1] <= '0; r_off[2] <= '0;
            r_sizes <= 24'h808080;
            r_min <= 16'sd32767;
            r_st <= ST_IDLE;
            r_cnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    atvr_pkg::REG_GAINS_Y:  r_gain[0] <= i_cfg_data;
                    atvr_pkg::REG_OFFSET_Y: r_off[0] <= i_cfg_data[31:0];
                    atvr_pkg::REG_GAINS_X:  r_gain[1] <= i_cfg_data;
                    atvr_pkg::REG_OFFSET_X: r_off[1] <= i_cfg_data[31:0];
                    atvr_pkg::REG_GAINS_Z:  r_gain[2] <= i_cfg_data;
                    atvr_pkg::REG_OFFSET_Z: r_off[2] <= i_cfg_data[31:0];
                    atvr_pkg::REG_SIZES:    r_sizes <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (out_set) r_ovalid <= 1'b1;
            else if (m_out.ready) r_ovalid <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (in_ok) begin
                        case (s_in.payload.cmd)
                            atvr_pkg::CMD_LOAD:
                                if (s_in.payload.src_value < r_min)
                                    r_min <= s_in.payload.src_value;
                            atvr_pkg::CMD_RESTART: r_min <= 16'sd32767;
                            atvr_pkg::CMD_SAMPLE: begin
                                r_crd[0] <= 9'(s_in.payload.out_row[CB-1:0]);
                                r_crd[1] <= 9'(s_in.payload.out_col[CB-1:0]);
                                r_crd[2] <= 9'(s_in.payload.out_slice[CB-1:0]);
                                r_sz[0] <= szc[0]; r_sz[1] <= szc[1]; r_sz[2] <= szc[2];
                                r_cnt <= '0;
                                r_st <= ST_MAP;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MAP: begin
                    // counter low bits step the gain, high bits the axis
                    if (r_cnt[1:0] == 2'd3) begin
                        r_pos[ax] <= acc[53:0];
                        if (r_cnt[3:2] == 2'd2) r_st <= ST_FLOOR;
                    end
                    r_cnt <= r_cnt + 4'd1;
                end
                ST_FLOOR: begin
                    for (int k = 0; k < 3; k++) begin
                        r_fr[k] <= r_pos[k][15:0];
                        r_fl[k] <= ($signed(r_pos[k][53:16]) < -38'sd1) ? -16'sd1 :
                                   ($signed(r_pos[k][53:16]) > 38'sd4096) ? 16'sd4096 :
                                   16'(r_pos[k][53:16]);
                    end
                    r_plane <= 18'(r_sz[0]) * r_sz[1];
                    r_st <= ST_ADDR;
                    r_cnt <= '0;
                end
                ST_ADDR: begin
                    if (outside_c) begin
                        if (out_free) begin
                            r_out.sample_value <= 24'(r_min) <<< 8;
                            r_out.outside <= 1'b1;
                            r_st <= ST_IDLE;
                        end
                    end else begin
                        r_addr <= flat[AW-1:0];
                        r_st <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_w <= 49'(w0) * w1;
                    r_st <= ST_WGT;
                end
                ST_WGT: begin
                    r_w <= 49'(r_w[32:0]) * w2;
                    r_st <= ST_MUL;
                end
                ST_MUL: r_st <= ST_LO;
                ST_LO: begin
                    if (nb == 3'd7) r_st <= ST_RND;
                    else begin
                        r_cnt <= r_cnt + 4'd1;
                        r_st <= ST_ADDR;
                    end
                end
                ST_RND: r_st <= ST_OUT;
                ST_OUT: begin
                    if (out_free) begin
                        r_out.sample_value <= accr[63:40];
                        r_out.outside <= 1'b0;
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
    assign m_out.valid = r_ovalid;
    assign m_out.payload = r_out;
endmodule
